/* hdl/fde_pkg.sv */
package fde_pkg;

  // delay store geometry
  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);

  // sample and coefficient widths
  localparam int SMP_W  = 10;
  localparam int FB_W   = 8;
  localparam int WET_W  = 9;
  localparam int CTR_W  = 12;   // doubled centred value, signed
  localparam int COEF_W = 10;   // q8 coefficient, signed
  localparam int PROD_W = CTR_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = 11;   // pre-volume level
  localparam int P_W    = T_W + SMP_W;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_EFFECT   = 3'd1;
  localparam logic [2:0] REG_OFFSET   = 3'd2;
  localparam logic [2:0] REG_FEEDBACK = 3'd3;
  localparam logic [2:0] REG_WET      = 3'd4;

  // effect modes
  localparam logic [1:0] MODE_CLEAN = 2'd0;
  localparam logic [1:0] MODE_ECHO  = 2'd1;
  localparam logic [1:0] MODE_DELAY = 2'd2;

  // reset values
  localparam logic [IDX_W-1:0] OFFSET_RST   = IDX_W'(500);
  localparam logic [FB_W-1:0]  FEEDBACK_RST = FB_W'(192);
  localparam logic [WET_W-1:0] WET_RST      = WET_W'(179);

  // item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_DONE
  } state_t;

  // commands from the sequencer to the delay store
  typedef struct packed {
    logic rd;        // read the delayed sample
    logic wr;        // write the feedback blend at the write index
    logic clean;     // clean step: zero entry 0, index to one
    logic mode_clr;  // mode register written: empty store, index to zero
  } store_ctl_t;

endpackage

/* hdl/fde_store.sv */
module fde_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fde_pkg::store_ctl_t      ctl,
  input  logic [fde_pkg::IDX_W-1:0] offset,
  input  logic [fde_pkg::SMP_W-1:0] wr_data,
  output logic [fde_pkg::SMP_W-1:0] rd_data
);
  import fde_pkg::*;

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rdata_r;
  logic             rd_ok_r;
  logic [IDX_W-1:0] wi_r;
  logic             full_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [SMP_W-1:0] wr_word;
  logic             wr_en;

  // read position trails the write index, wrapping round the store
  assign rd_addr = wi_r - offset;

  // clean steps write zero into entry 0 so it reads back as cleared
  assign wr_en   = ctl.wr | ctl.clean;
  assign wr_addr = ctl.clean ? '0 : wi_r;
  assign wr_word = ctl.clean ? '0 : wr_data;

  // synchronous memory, one read and one write port
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  // entries written since the last clear are those below the write index,
  // or every entry once the index has wrapped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (ctl.rd) begin
      rd_ok_r <= full_r | (rd_addr < wi_r);
    end
  end

  // write index and wrap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r   <= '0;
      full_r <= 1'b0;
    end else if (ctl.mode_clr) begin
      wi_r   <= '0;
      full_r <= 1'b0;
    end else if (ctl.clean) begin
      wi_r   <= IDX_W'(1);
      full_r <= 1'b0;
    end else if (ctl.wr) begin
      wi_r <= wi_r + IDX_W'(1);
      if (wi_r == IDX_W'(DEPTH - 1)) begin
        full_r <= 1'b1;
      end
    end
  end

  // unwritten entries read as cleared
  assign rd_data = rd_ok_r ? rdata_r : '0;

endmodule

/* hdl/fde_mix.sv */
module fde_mix (
  input  logic                       clk,
  input  logic                       mul_en,
  input  logic                       sum_en,
  input  logic                       clean,
  input  logic                       dly_sel,
  input  logic [fde_pkg::SMP_W-1:0]  x,
  input  logic [fde_pkg::SMP_W-1:0]  delayed,
  input  logic [fde_pkg::FB_W-1:0]   feedback,
  input  logic [fde_pkg::WET_W-1:0]  wet,
  output logic [fde_pkg::SMP_W-1:0]  store_val,
  output logic [fde_pkg::T_W-1:0]    t_r
);
  import fde_pkg::*;

  localparam logic signed [CTR_W-1:0]  CENTRE = CTR_W'(1023);
  localparam logic signed [COEF_W-1:0] UNITY  = COEF_W'(256);
  localparam logic signed [SUM_W-1:0]  BIAS   = SUM_W'(1023 * 256);

  logic signed [CTR_W-1:0]  ci;
  logic signed [CTR_W-1:0]  cd;
  logic signed [COEF_W-1:0] fb_s;
  logic signed [COEF_W-1:0] wet_s;
  logic signed [COEF_W-1:0] ka;
  logic signed [COEF_W-1:0] kc;
  logic signed [COEF_W-1:0] kd;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [SUM_W-1:0]  n_sum;
  logic signed [SUM_W-1:0]  o_sum;
  logic [T_W-1:0]           t_nxt;

  // doubled centred values
  assign ci = $signed({1'b0, x, 1'b0}) - CENTRE;
  assign cd = $signed({1'b0, delayed, 1'b0}) - CENTRE;

  // q8 weights: echo blends by feedback and wet share, delay sums
  assign fb_s  = $signed({2'b00, feedback});
  assign wet_s = $signed({1'b0, wet});
  assign ka = dly_sel ? UNITY : UNITY - fb_s;
  assign kc = dly_sel ? UNITY : UNITY - wet_s;
  assign kd = dly_sel ? UNITY : wet_s;

  // four products, registered
  always_ff @(posedge clk) begin
    if (mul_en) begin
      pa_r <= ci * ka;
      pb_r <= cd * fb_s;
      pc_r <= ci * kc;
      pd_r <= cd * kd;
    end
  end

  // re-biased numerators
  assign n_sum = $signed({pa_r[PROD_W-1], pa_r}) + $signed({pb_r[PROD_W-1], pb_r}) + BIAS;
  assign o_sum = $signed({pc_r[PROD_W-1], pc_r}) + $signed({pd_r[PROD_W-1], pd_r}) + BIAS;

  // stored value: divide by 512, clamp to 0..1023
  always_comb begin
    if (n_sum[SUM_W-1]) begin
      store_val = '0;
    end else if (n_sum[SUM_W-2:9+SMP_W] != '0) begin
      store_val = '1;
    end else begin
      store_val = n_sum[9+SMP_W-1:9];
    end
  end

  // pre-volume level, clean steps pass the input through
  always_comb begin
    if (clean) begin
      t_nxt = {1'b0, x};
    end else if (o_sum[SUM_W-1]) begin
      t_nxt = '0;
    end else begin
      t_nxt = o_sum[9+T_W-1:9];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      t_r <= t_nxt;
    end
  end

endmodule

/* hdl/fde_scale.sv */
module fde_scale (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fde_pkg::T_W-1:0]   t,
  input  logic [fde_pkg::SMP_W-1:0] vol,
  output logic [fde_pkg::SMP_W-1:0] level
);
  import fde_pkg::*;

  localparam int Q_W = T_W + 1;

  logic [P_W-1:0] p_r;
  logic [T_W-1:0] q0;
  logic [Q_W-1:0] rem;
  logic [1:0]     corr;
  logic [Q_W-1:0] q;

  // level times volume, registered
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= t * vol;
    end
  end

  // divide by 1023: p/1024 undershoots, and p - q0*1023 = p mod 1024 + q0
  // stays below three times the divisor plus one
  assign q0  = p_r[P_W-1:SMP_W];
  assign rem = {2'b00, p_r[SMP_W-1:0]} + {1'b0, q0};

  always_comb begin
    if (rem >= Q_W'(3 * 1023)) begin
      corr = 2'd3;
    end else if (rem >= Q_W'(2 * 1023)) begin
      corr = 2'd2;
    end else if (rem >= Q_W'(1023)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  assign q = {1'b0, q0} + {{(Q_W-2){1'b0}}, corr};

  // clamp to full scale
  assign level = (q > Q_W'(1023)) ? '1 : q[SMP_W-1:0];

endmodule

/* hdl/feedback_delay_echo.sv */
// Echo and repeating-delay effect for a 10-bit audio stream. Each input word
// carries a raw sample and a master volume and yields one output word with
// the processed sample and its two PWM bytes. A word is accepted, its delayed
// sample read from the 1024-entry store, blended by four q8 multipliers, the
// feedback blend written back, then scaled by volume/1023 and placed in the
// output register, stepping through the multiply, sum, scale and done states;
// the next word is taken in the cycle that loads the result, and no word is
// taken while one is in flight or while the done state stalls on the output.
// The output register lets a new word in while a result waits. The store needs
// no clearing pass: after reset, a mode write or a clean step, entries not yet
// rewritten read as zero. Write the configuration registers only while the
// block is idle.
module feedback_delay_echo (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // sample_in [9:0], volume [19:10], zero [23:20]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // sample_out [9:0], pwm_high_byte [17:10],
                                   // pwm_low_byte [25:18], zero [31:26]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fde_pkg::*;

  state_t           state_r, state_nxt;
  logic [1:0]       mode_r;
  logic             effect_on_r;
  logic [IDX_W-1:0] offset_r;
  logic [FB_W-1:0]  feedback_r;
  logic [WET_W-1:0] wet_r;
  logic [SMP_W-1:0] x_r;
  logic [SMP_W-1:0] vol_r;
  logic             out_valid_r;
  logic [SMP_W-1:0] out_smp_r;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             effect;
  store_ctl_t       st_ctl;
  logic [SMP_W-1:0] delayed;
  logic [SMP_W-1:0] store_val;
  logic [T_W-1:0]   t_lvl;
  logic [SMP_W-1:0] level;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CLEAN;
      effect_on_r <= 1'b0;
      offset_r    <= OFFSET_RST;
      feedback_r  <= FEEDBACK_RST;
      wet_r       <= WET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:     mode_r      <= cfg_pwdata[1:0];
        REG_EFFECT:   effect_on_r <= cfg_pwdata[0];
        REG_OFFSET:   offset_r    <= cfg_pwdata[IDX_W-1:0];
        REG_FEEDBACK: feedback_r  <= cfg_pwdata[FB_W-1:0];
        REG_WET:      wet_r       <= cfg_pwdata[WET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:     cfg_prdata = {30'd0, mode_r};
      REG_EFFECT:   cfg_prdata = {31'd0, effect_on_r};
      REG_OFFSET:   cfg_prdata = {{(32-IDX_W){1'b0}}, offset_r};
      REG_FEEDBACK: cfg_prdata = {{(32-FB_W){1'b0}}, feedback_r};
      REG_WET:      cfg_prdata = {{(32-WET_W){1'b0}}, wet_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // effect active only in echo or delay mode
  assign effect = effect_on_r & ((mode_r == MODE_ECHO) | (mode_r == MODE_DELAY));

  // handshake
  assign out_free  = ~out_valid_r | out_tready;
  assign in_accept = in_tvalid & in_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          in_tready = 1'b1;
          state_nxt = in_tvalid ? ST_MUL : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r   <= in_tdata[SMP_W-1:0];
      vol_r <= in_tdata[2*SMP_W-1:SMP_W];
    end
  end

  // store commands; the write lands before any later read
  assign st_ctl.rd       = in_accept;
  assign st_ctl.wr       = (state_r == ST_SUM) & effect;
  assign st_ctl.clean    = (state_r == ST_SUM) & ~effect;
  assign st_ctl.mode_clr = cfg_wr & (cfg_idx == REG_MODE);

  fde_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .offset  (offset_r),
    .wr_data (store_val),
    .rd_data (delayed)
  );

  fde_mix u_mix (
    .clk        (clk),
    .mul_en     (state_r == ST_MUL),
    .sum_en     (state_r == ST_SUM),
    .clean      (~effect),
    .dly_sel    (mode_r == MODE_DELAY),
    .x          (x_r),
    .delayed    (delayed),
    .feedback   (feedback_r),
    .wet        (wet_r),
    .store_val  (store_val),
    .t_r        (t_lvl)
  );

  fde_scale u_scale (
    .clk   (clk),
    .en    (state_r == ST_SCALE),
    .t     (t_lvl),
    .vol   (vol_r),
    .level (level)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_smp_r <= level;
    end
  end

  // high pwm byte is 0x80 plus the top two sample bits
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_smp_r[7:0], 6'b100000, out_smp_r[9:8], out_smp_r};

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_MUL)
    else $error("accepted word did not start the multiply step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_DONE)
    else $error("result appeared outside the finishing step");

  a_single_store_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({st_ctl.wr, st_ctl.clean, st_ctl.mode_clr}))
    else $error("store write and clear overlap");

  a_no_accept_midway: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> !in_accept ##1 !in_accept)
    else $error("word accepted while the previous one is in flight");
`endif

endmodule

/* sim/feedback_delay_echo_test.sv */
module feedback_delay_echo_test;
  import fde_pkg::*;

  // one output word split into its fields
  typedef struct packed {
    logic [9:0] level;
    logic [7:0] pwm_hi;
    logic [7:0] pwm_lo;
  } out_word_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    logic [9:0]  smp;
    logic [9:0]  vol;
    bit          typed;
    out_word_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;     // sample_in [9:0], volume [19:10], zero [23:20]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // sample_out [9:0], pwm_high_byte [17:10],
                             // pwm_low_byte [25:18], zero [31:26]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the effect state and registers
  logic [9:0] delay_mem [DEPTH];
  logic [9:0] wr_ptr;
  logic [1:0] cur_mode;
  logic       cur_effect;
  logic [9:0] cur_offset;
  logic [7:0] cur_fb;
  logic [8:0] cur_wet;

  out_word_t awaited[$];
  stim_row_t plan[$];
  int        faults;
  bit        idle_on;
  bit        hold_req;

  feedback_delay_echo dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("feedback_delay_echo test failed");
    $finish;
  end

  task automatic note_fault(string what, int exp_val, int act_val);
    faults++;
    if (faults <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
  endtask

  function automatic void clear_store();
    for (int i = 0; i < DEPTH; i++)
      delay_mem[i] = '0;
    wr_ptr = '0;
  endfunction

  // add the doubled bias back and halve the q8 scale, floored at zero
  function automatic int rebias(int num);
    int s;
    s = num + 1023 * 256;
    return (s < 0) ? 0 : s / 512;
  endfunction

  // one sample through the effect, updating the shadow store
  function automatic out_word_t echo_output(logic [9:0] smp, logic [9:0] vol);
    int         ci, cd, f, w, n, o, st, t, s;
    logic [9:0] rd;
    out_word_t  r;
    if (cur_effect && (cur_mode == MODE_ECHO || cur_mode == MODE_DELAY)) begin
      rd = wr_ptr - cur_offset;
      ci = 2 * int'(smp) - 1023;
      cd = 2 * int'(delay_mem[rd]) - 1023;
      f  = int'(cur_fb);
      w  = int'(cur_wet);
      if (cur_mode == MODE_ECHO) begin
        n = ci * (256 - f) + cd * f;
        o = ci * (256 - w) + cd * w;
      end else begin
        n = ci * 256 + cd * f;
        o = (ci + cd) * 256;
      end
      st = rebias(n);
      if (st > 1023) st = 1023;
      delay_mem[wr_ptr] = st[9:0];
      t = rebias(o);
    end else begin
      // bypass empties the store
      clear_store();
      t = int'(smp);
    end
    wr_ptr = wr_ptr + 10'd1;
    s = t * int'(vol) / 1023;
    if (s > 1023) s = 1023;
    r.level  = s[9:0];
    r.pwm_hi = 8'((s + 32'h8000) >> 8);
    r.pwm_lo = s[7:0];
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [9:0] smp, logic [9:0] vol, bit typed,
                                         int lvl, int hi, int lo);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.value = '0;
    r.smp = smp;
    r.vol = vol;
    r.typed = typed;
    r.want.level = 10'(lvl);
    r.want.pwm_hi = 8'(hi);
    r.want.pwm_lo = 8'(lo);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, int val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  // offer one word, predict its output once it is taken
  task automatic send_word(logic [9:0] smp, logic [9:0] vol, bit typed, out_word_t want);
    out_word_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, vol, smp};
    do @(posedge clk); while (!in_tready);
    pred = echo_output(smp, vol);
    awaited.push_back(typed ? want : pred);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // register write once the pipe is empty, then read it back
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] mask;
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MODE: begin
        mask = 32'h3;
        cur_mode = val[1:0];
        clear_store();
      end
      REG_EFFECT: begin
        mask = 32'h1;
        cur_effect = val[0];
      end
      REG_OFFSET: begin
        mask = 32'h3ff;
        cur_offset = val[9:0];
      end
      REG_FEEDBACK: begin
        mask = 32'hff;
        cur_fb = val[7:0];
      end
      default: begin
        mask = 32'h1ff;
        cur_wet = val[8:0];
      end
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata != (val & mask))
      note_fault("register readback", int'(val & mask), int'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // compare a taken output word with the oldest prediction
  task automatic take_output(logic [31:0] word);
    out_word_t want;
    if (awaited.size() == 0) begin
      note_fault("output word with none awaited", 0, int'(word));
      return;
    end
    want = awaited.pop_front();
    if (word[9:0] != want.level)
      note_fault("sample_out", want.level, word[9:0]);
    if (word[17:10] != want.pwm_hi)
      note_fault("pwm_high_byte", want.pwm_hi, word[17:10]);
    if (word[25:18] != want.pwm_lo)
      note_fault("pwm_low_byte", want.pwm_lo, word[25:18]);
  endtask

  // output side: random stalls and one long hold-off
  initial begin
    int stall_left = 0;
    int hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        take_output(out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 200;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    logic [9:0] smp, vol;
    int         mode_pick;
    out_word_t  none;
    none        = '0;
    faults      = 0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    clear_store();
    cur_mode   = MODE_CLEAN;
    cur_effect = 1'b0;
    cur_offset = OFFSET_RST;
    cur_fb     = FEEDBACK_RST;
    cur_wet    = WET_RST;

    // directed table: bypass extremes after reset, then every mode and edge
    plan.push_back(item_row(10'd1023, 10'd1023, 1, 1023, 131, 255));
    plan.push_back(item_row(10'd0,    10'd1023, 1, 0, 128, 0));
    plan.push_back(item_row(10'd1023, 10'd0,    1, 0, 128, 0));
    plan.push_back(item_row(10'd512,  10'd1023, 1, 512, 130, 0));
    plan.push_back(item_row(10'd1023, 10'd1,    1, 1, 128, 1));
    plan.push_back(cfg_row(REG_EFFECT, 1));
    plan.push_back(item_row(10'd700,  10'd800,  0, 0, 0, 0));
    // echo, shortest offset, full feedback and wet
    plan.push_back(cfg_row(REG_MODE, MODE_ECHO));
    plan.push_back(cfg_row(REG_OFFSET, 1));
    plan.push_back(cfg_row(REG_FEEDBACK, 255));
    plan.push_back(cfg_row(REG_WET, 256));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd0,    10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd511,  10'd1023, 0, 0, 0, 0));
    // wet above unity, offset zero reads the entry being written
    plan.push_back(cfg_row(REG_WET, 511));
    plan.push_back(cfg_row(REG_OFFSET, 0));
    plan.push_back(item_row(10'd0,    10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    // repeating delay, longest offset, no feedback
    plan.push_back(cfg_row(REG_MODE, MODE_DELAY));
    plan.push_back(cfg_row(REG_OFFSET, 1023));
    plan.push_back(cfg_row(REG_FEEDBACK, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd0,    10'd512,  0, 0, 0, 0));
    // saturating feedback loop
    plan.push_back(cfg_row(REG_FEEDBACK, 255));
    plan.push_back(cfg_row(REG_OFFSET, 2));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 0, 0, 0, 0));
    // unused mode code acts as clean
    plan.push_back(cfg_row(REG_MODE, 3));
    plan.push_back(item_row(10'd300,  10'd1023, 1, 300, 129, 44));
    // effect off bypasses whatever the mode
    plan.push_back(cfg_row(REG_MODE, MODE_ECHO));
    plan.push_back(cfg_row(REG_EFFECT, 0));
    plan.push_back(item_row(10'd1023, 10'd1023, 1, 1023, 131, 255));
    plan.push_back(cfg_row(REG_EFFECT, 1));
    plan.push_back(item_row(10'd100,  10'd1023, 0, 0, 0, 0));
    plan.push_back(item_row(10'd900,  10'd1023, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].reg_idx, plan[i].value);
      else
        send_word(plan[i].smp, plan[i].vol, plan[i].typed, plan[i].want);
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 10) idle_on = 1'b0;
      if (ph == 0 || $urandom_range(0, 2) == 0) begin
        mode_pick = $urandom_range(0, 7);
        write_reg(REG_MODE, (mode_pick == 0) ? MODE_CLEAN :
                            (mode_pick == 1) ? 3 :
                            (mode_pick < 5)  ? MODE_ECHO : MODE_DELAY);
      end
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_EFFECT, ($urandom_range(0, 4) != 0) ? 1 : 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_OFFSET, 0);
          1:       write_reg(REG_OFFSET, 1);
          2:       write_reg(REG_OFFSET, 1023);
          3:       write_reg(REG_OFFSET, 500);
          default: write_reg(REG_OFFSET, $urandom_range(2, 64));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_FEEDBACK, 0);
          1:       write_reg(REG_FEEDBACK, 255);
          default: write_reg(REG_FEEDBACK, $urandom_range(0, 255));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(REG_WET, 0);
          1:       write_reg(REG_WET, 256);
          2:       write_reg(REG_WET, 511);
          default: write_reg(REG_WET, $urandom_range(0, 256));
        endcase
      end
      // the output side holds off while input keeps coming
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < 94; k++) begin
        case ($urandom_range(0, 9))
          0:       smp = 10'd0;
          1:       smp = 10'd1023;
          default: smp = 10'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 9))
          0:       vol = 10'd1023;
          1:       vol = 10'd0;
          2, 3, 4: vol = 10'($urandom_range(900, 1023));
          default: vol = 10'($urandom_range(0, 1023));
        endcase
        send_word(smp, vol, 1'b0, none);
      end
    end

    // drain and let the pipe settle
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (faults == 0)
      $display("feedback_delay_echo test passed");
    else
      $display("feedback_delay_echo test failed");
    $finish;
  end

endmodule

/* feedback_delay_echo.f */
hdl/fde_pkg.sv
hdl/fde_store.sv
hdl/fde_mix.sv
hdl/fde_scale.sv
hdl/feedback_delay_echo.sv
sim/feedback_delay_echo_test.sv
